// ===== hdl/dctc_pkg.sv =====
// ----------------------------------------------------------------------------
// DRAM command timing checker package
// Command codes, command kinds, rule table and shared helper functions.
// ----------------------------------------------------------------------------
package dctc_pkg;

  localparam int BANKS_DEF       = 32;
  localparam int BANK_GROUPS_DEF = 8;
  localparam int RANKS_DEF       = 2;
  localparam int TIME_BITS_DEF   = 48;

  localparam int ACT_WINDOW  = 4;
  localparam int BANK_KINDS  = 7;
  localparam int GROUP_KINDS = 5;
  localparam int RANK_KINDS  = 9;
  localparam int ALL_KINDS   = 15;
  localparam int OFF_BITS    = 18;
  localparam int OUT_BITS    = 48;

  localparam logic [4:0] CMD_RD     = 5'd0;
  localparam logic [4:0] CMD_RDA    = 5'd1;
  localparam logic [4:0] CMD_WR     = 5'd2;
  localparam logic [4:0] CMD_WRA    = 5'd3;
  localparam logic [4:0] CMD_MWR    = 5'd4;
  localparam logic [4:0] CMD_MWRA   = 5'd5;
  localparam logic [4:0] CMD_ACT    = 5'd6;
  localparam logic [4:0] CMD_PREPB  = 5'd7;
  localparam logic [4:0] CMD_PREAB  = 5'd8;
  localparam logic [4:0] CMD_REFAB  = 5'd9;
  localparam logic [4:0] CMD_REFPB  = 5'd10;
  localparam logic [4:0] CMD_PDEA   = 5'd11;
  localparam logic [4:0] CMD_PDXA   = 5'd12;
  localparam logic [4:0] CMD_PDEP   = 5'd13;
  localparam logic [4:0] CMD_PDXP   = 5'd14;
  localparam logic [4:0] CMD_SREFEN = 5'd15;
  localparam logic [4:0] CMD_SREFEX = 5'd16;

  localparam logic [2:0] CFG_ACT_WORD  = 3'd0;
  localparam logic [2:0] CFG_COL_WORD  = 3'd1;
  localparam logic [2:0] CFG_TURN_WORD = 3'd2;
  localparam logic [2:0] CFG_REF_WORD  = 3'd3;
  localparam logic [2:0] CFG_BPR       = 3'd4;

  typedef enum logic [3:0] {
    K_RD = 4'd0, K_RDA = 4'd1, K_WR = 4'd2, K_WRA = 4'd3, K_ACT = 4'd4,
    K_PREPB = 4'd5, K_REFPB = 4'd6, K_PREAB = 4'd7, K_REFAB = 4'd8,
    K_PDEA = 4'd9, K_PDXA = 4'd10, K_PDEP = 4'd11, K_PDXP = 4'd12,
    K_SREFEN = 4'd13, K_SREFEX = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    SRC_BANK = 3'd0, SRC_GROUP = 3'd1, SRC_RANK = 3'd2, SRC_GLOBAL = 3'd3,
    SRC_FAW = 3'd4, SRC_BUS = 3'd5
  } src_t;

  typedef enum logic [5:0] {
    O_ONE, O_RCDRD1, O_RCDWR1, O_CCDL, O_CCDS, O_WRPRE_M_RTP, O_WRRDL, O_WRRDS,
    O_XP, O_RTW, O_RC, O_RRDL, O_RRDS, O_RTPRP_M1, O_WRPRERP_M1, O_RP_M1,
    O_XP_M1, O_RFC_M1, O_RFCSB_M1, O_RREFD_M1, O_XS_M1, O_FAW_M1, O_RAS1,
    O_RTP, O_WRPRE, O_RFCSB, O_RC1, O_RTPRP, O_WRPRERP, O_RP, O_RFC, O_XS,
    O_RRDL1, O_RRDS1, O_REFCNT, O_FAW, O_RDPDE, O_WRPDE, O_CKE, O_PD,
    O_RDSRE, O_CKESR
  } off_t;

  typedef struct packed {
    src_t  src;
    kind_t kind;
    off_t  off;
    logic  last;
  } step_t;

  localparam step_t BUS_STEP = '{src: SRC_BUS, kind: K_RD, off: O_ONE, last: 1'b1};

  function automatic step_t mk(input src_t s, input kind_t k, input off_t o);
    return '{src: s, kind: k, off: o, last: 1'b0};
  endfunction

  function automatic kind_t cmd_kind(input logic [4:0] c);
    kind_t k;
    unique case (c)
      CMD_RD:     k = K_RD;
      CMD_RDA:    k = K_RDA;
      CMD_WR:     k = K_WR;
      CMD_WRA:    k = K_WRA;
      CMD_MWR:    k = K_WR;
      CMD_MWRA:   k = K_WRA;
      CMD_ACT:    k = K_ACT;
      CMD_PREPB:  k = K_PREPB;
      CMD_PREAB:  k = K_PREAB;
      CMD_REFAB:  k = K_REFAB;
      CMD_REFPB:  k = K_REFPB;
      CMD_PDEA:   k = K_PDEA;
      CMD_PDXA:   k = K_PDXA;
      CMD_PDEP:   k = K_PDEP;
      CMD_PDXP:   k = K_PDXP;
      CMD_SREFEN: k = K_SREFEN;
      CMD_SREFEX: k = K_SREFEX;
      default:    k = K_RD;
    endcase
    return k;
  endfunction

  // Remainder of a small index by a small constant, by restoring subtraction.
  function automatic logic [6:0] mod_small(input logic [6:0] v, input logic [6:0] m);
    logic [12:0] r;
    logic [12:0] d;
    r = 13'(v);
    for (int j = 4; j >= 0; j--) begin
      d = 13'(m) << j;
      if (r >= d) r = r - d;
    end
    return r[6:0];
  endfunction

  // Rule list of each command kind; the bus rule closes every list.
  function automatic step_t rule_step(input kind_t k, input logic [3:0] i);
    step_t s;
    s = BUS_STEP;
    unique case (k)
      K_RD, K_RDA: begin
        unique case (i)
          4'd0:  s = mk(SRC_BANK, K_ACT, O_RCDRD1);
          4'd1:  s = mk(SRC_GROUP, K_RD, O_CCDL);
          4'd2:  s = mk(SRC_RANK, K_RD, O_CCDS);
          4'd3:  s = mk(SRC_GROUP, K_RDA, O_CCDL);
          4'd4:  s = mk(SRC_RANK, K_RDA, O_CCDS);
          4'd5:  s = mk(SRC_GROUP, K_WR, O_WRRDL);
          4'd6:  s = mk(SRC_RANK, K_WR, O_WRRDS);
          4'd7:  s = mk(SRC_GROUP, K_WRA, O_WRRDL);
          4'd8:  s = mk(SRC_RANK, K_WRA, O_WRRDS);
          4'd9:  s = mk(SRC_GLOBAL, K_PDXA, O_XP);
          4'd10: if (k == K_RDA) s = mk(SRC_BANK, K_WR, O_WRPRE_M_RTP);
          default: s = BUS_STEP;
        endcase
      end
      K_WR, K_WRA: begin
        unique case (i)
          4'd0: s = mk(SRC_BANK, K_ACT, O_RCDWR1);
          4'd1: s = mk(SRC_RANK, K_RD, O_RTW);
          4'd2: s = mk(SRC_RANK, K_RDA, O_RTW);
          4'd3: s = mk(SRC_GROUP, K_WR, O_CCDL);
          4'd4: s = mk(SRC_RANK, K_WR, O_CCDS);
          4'd5: s = mk(SRC_GROUP, K_WRA, O_CCDL);
          4'd6: s = mk(SRC_RANK, K_WRA, O_CCDS);
          4'd7: s = mk(SRC_GLOBAL, K_PDXA, O_XP);
          default: s = BUS_STEP;
        endcase
      end
      K_ACT: begin
        unique case (i)
          4'd0:  s = mk(SRC_BANK, K_ACT, O_RC);
          4'd1:  s = mk(SRC_GROUP, K_ACT, O_RRDL);
          4'd2:  s = mk(SRC_RANK, K_ACT, O_RRDS);
          4'd3:  s = mk(SRC_BANK, K_RDA, O_RTPRP_M1);
          4'd4:  s = mk(SRC_BANK, K_WRA, O_WRPRERP_M1);
          4'd5:  s = mk(SRC_BANK, K_PREPB, O_RP_M1);
          4'd6:  s = mk(SRC_RANK, K_PREAB, O_RP_M1);
          4'd7:  s = mk(SRC_GLOBAL, K_PDXA, O_XP_M1);
          4'd8:  s = mk(SRC_GLOBAL, K_PDXP, O_XP_M1);
          4'd9:  s = mk(SRC_RANK, K_REFAB, O_RFC_M1);
          4'd10: s = mk(SRC_BANK, K_REFPB, O_RFCSB_M1);
          4'd11: s = mk(SRC_RANK, K_REFPB, O_RREFD_M1);
          4'd12: s = mk(SRC_GLOBAL, K_SREFEX, O_XS_M1);
          4'd13: s = mk(SRC_FAW, K_ACT, O_FAW_M1);
          default: s = BUS_STEP;
        endcase
      end
      K_PREPB: begin
        unique case (i)
          4'd0: s = mk(SRC_BANK, K_ACT, O_RAS1);
          4'd1: s = mk(SRC_BANK, K_RD, O_RTP);
          4'd2: s = mk(SRC_BANK, K_WR, O_WRPRE);
          4'd3: s = mk(SRC_GLOBAL, K_PDXA, O_XP);
          default: s = BUS_STEP;
        endcase
      end
      K_PREAB: begin
        unique case (i)
          4'd0: s = mk(SRC_RANK, K_ACT, O_RAS1);
          4'd1: s = mk(SRC_RANK, K_RD, O_RTP);
          4'd2: s = mk(SRC_RANK, K_RDA, O_RTP);
          4'd3: s = mk(SRC_RANK, K_WR, O_WRPRE);
          4'd4: s = mk(SRC_RANK, K_WRA, O_WRPRE);
          4'd5: s = mk(SRC_GLOBAL, K_PDXA, O_XP);
          4'd6: s = mk(SRC_RANK, K_REFPB, O_RFCSB);
          default: s = BUS_STEP;
        endcase
      end
      K_REFAB: begin
        unique case (i)
          4'd0: s = mk(SRC_RANK, K_ACT, O_RC1);
          4'd1: s = mk(SRC_RANK, K_RDA, O_RTPRP);
          4'd2: s = mk(SRC_RANK, K_WRA, O_WRPRERP);
          4'd3: s = mk(SRC_RANK, K_PREPB, O_RP);
          4'd4: s = mk(SRC_RANK, K_PREAB, O_RP);
          4'd5: s = mk(SRC_GLOBAL, K_PDXP, O_XP);
          4'd6: s = mk(SRC_RANK, K_REFAB, O_RFC);
          4'd7: s = mk(SRC_RANK, K_REFPB, O_RFCSB);
          4'd8: s = mk(SRC_GLOBAL, K_SREFEX, O_XS);
          default: s = BUS_STEP;
        endcase
      end
      K_REFPB: begin
        unique case (i)
          4'd0:  s = mk(SRC_BANK, K_ACT, O_RC1);
          4'd1:  s = mk(SRC_GROUP, K_ACT, O_RRDL1);
          4'd2:  s = mk(SRC_RANK, K_ACT, O_RRDS1);
          4'd3:  s = mk(SRC_BANK, K_RDA, O_RTPRP);
          4'd4:  s = mk(SRC_BANK, K_WRA, O_WRPRERP);
          4'd5:  s = mk(SRC_BANK, K_PREPB, O_RP);
          4'd6:  s = mk(SRC_RANK, K_PREAB, O_RP);
          4'd7:  s = mk(SRC_GLOBAL, K_PDXA, O_XP);
          4'd8:  s = mk(SRC_GLOBAL, K_PDXP, O_XP);
          4'd9:  s = mk(SRC_RANK, K_REFAB, O_RFC);
          4'd10: s = mk(SRC_BANK, K_REFPB, O_RFCSB);
          4'd11: s = mk(SRC_RANK, K_REFPB, O_REFCNT);
          4'd12: s = mk(SRC_GLOBAL, K_SREFEX, O_XS);
          4'd13: s = mk(SRC_FAW, K_ACT, O_FAW);
          default: s = BUS_STEP;
        endcase
      end
      K_PDEA: begin
        unique case (i)
          4'd0: s = mk(SRC_GLOBAL, K_RD, O_RDPDE);
          4'd1: s = mk(SRC_GLOBAL, K_RDA, O_RDPDE);
          4'd2: s = mk(SRC_GLOBAL, K_WR, O_WRPDE);
          4'd3: s = mk(SRC_GLOBAL, K_WRA, O_WRPDE);
          4'd4: s = mk(SRC_GLOBAL, K_PDXA, O_CKE);
          default: s = BUS_STEP;
        endcase
      end
      K_PDXA: begin
        if (i == 4'd0) s = mk(SRC_GLOBAL, K_PDEA, O_PD);
      end
      K_PDEP: begin
        unique case (i)
          4'd0: s = mk(SRC_GLOBAL, K_RD, O_RDPDE);
          4'd1: s = mk(SRC_GLOBAL, K_RDA, O_RDPDE);
          4'd2: s = mk(SRC_GLOBAL, K_WRA, O_WRPDE);
          4'd3: s = mk(SRC_GLOBAL, K_PDXP, O_CKE);
          4'd4: s = mk(SRC_GLOBAL, K_SREFEX, O_XS);
          default: s = BUS_STEP;
        endcase
      end
      K_PDXP: begin
        if (i == 4'd0) s = mk(SRC_GLOBAL, K_PDEP, O_PD);
      end
      K_SREFEN: begin
        unique case (i)
          4'd0: s = mk(SRC_GLOBAL, K_ACT, O_RC1);
          4'd1: s = mk(SRC_GLOBAL, K_RDA, O_RDSRE);
          4'd2: s = mk(SRC_GLOBAL, K_WRA, O_WRPRERP);
          4'd3: s = mk(SRC_GLOBAL, K_PREPB, O_RP);
          4'd4: s = mk(SRC_GLOBAL, K_PREAB, O_RP);
          4'd5: s = mk(SRC_GLOBAL, K_PDXP, O_XP);
          4'd6: s = mk(SRC_GLOBAL, K_REFAB, O_RFC);
          4'd7: s = mk(SRC_GLOBAL, K_REFPB, O_RFCSB);
          4'd8: s = mk(SRC_GLOBAL, K_SREFEX, O_XS);
          default: s = BUS_STEP;
        endcase
      end
      default: begin
        if (i == 4'd0) s = mk(SRC_GLOBAL, K_SREFEN, O_CKESR);
      end
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/dctc_issue_mem.sv =====
// ----------------------------------------------------------------------------
// Issue time memory
// Synchronous single-port-write, single-port-read store of issue times with
// a valid bit per entry that reset clears.
// ----------------------------------------------------------------------------
module dctc_issue_mem #(
  parameter int DEPTH = 224,
  parameter int WIDTH = dctc_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  output logic                     rd_valid
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== hdl/dctc_rule_eval.sv =====
// ----------------------------------------------------------------------------
// Rule evaluator
// Forms the signed offset of one timing rule and adds it to an issue time
// with saturation, registering the candidate time.
// ----------------------------------------------------------------------------
module dctc_rule_eval #(
  parameter int TIME_BITS = dctc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  dctc_pkg::off_t       off,
  input  logic [63:0]          act_word,
  input  logic [63:0]          col_word,
  input  logic [63:0]          turn_word,
  input  logic [47:0]          ref_word,
  input  logic                 refcnt_zero,
  input  logic [TIME_BITS-1:0] entry_time,
  input  logic                 entry_valid,
  output logic                 cand_valid,
  output logic [TIME_BITS-1:0] cand_time
);

  localparam int OB = dctc_pkg::OFF_BITS;
  localparam int W  = TIME_BITS + OB;
  localparam logic signed [OB-1:0] ONE = OB'(1);

  logic signed [OB-1:0] t_rcdrd, t_rcdwr, t_rc, t_ras, t_rp, t_rrdl, t_rrds, t_faw;
  logic signed [OB-1:0] t_ccdl, t_ccds, t_rtw, t_rtp, t_rl, t_wl, t_wr, t_pl;
  logic signed [OB-1:0] t_wtrs, t_wtrl, t_bur, t_xp, t_cke, t_pd, t_ckesr, t_rrefd;
  logic signed [OB-1:0] t_rfc, t_rfcsb, t_xs;
  logic signed [OB-1:0] t_rdpde, t_wrpre, t_wrpde, t_wrrds, t_wrrdl, t_rtprp, t_rdsre;
  logic signed [OB-1:0] off_val;
  logic [W-1:0]         sum;
  logic [TIME_BITS-1:0] sat;
  logic                 cand_valid_r;
  logic [TIME_BITS-1:0] cand_time_r;

  assign t_rcdrd = OB'(act_word[7:0]);
  assign t_rcdwr = OB'(act_word[15:8]);
  assign t_rc    = OB'(act_word[23:16]);
  assign t_ras   = OB'(act_word[31:24]);
  assign t_rp    = OB'(act_word[39:32]);
  assign t_rrdl  = OB'(act_word[47:40]);
  assign t_rrds  = OB'(act_word[55:48]);
  assign t_faw   = OB'(act_word[63:56]);
  assign t_ccdl  = OB'(col_word[7:0]);
  assign t_ccds  = OB'(col_word[15:8]);
  assign t_rtw   = OB'(col_word[23:16]);
  assign t_rtp   = OB'(col_word[31:24]);
  assign t_rl    = OB'(col_word[39:32]);
  assign t_wl    = OB'(col_word[47:40]);
  assign t_wr    = OB'(col_word[55:48]);
  assign t_pl    = OB'(col_word[63:56]);
  assign t_wtrs  = OB'(turn_word[7:0]);
  assign t_wtrl  = OB'(turn_word[15:8]);
  assign t_bur   = OB'(turn_word[23:16]);
  assign t_xp    = OB'(turn_word[31:24]);
  assign t_cke   = OB'(turn_word[39:32]);
  assign t_pd    = OB'(turn_word[47:40]);
  assign t_ckesr = OB'(turn_word[55:48]);
  assign t_rrefd = OB'(turn_word[63:56]);
  assign t_rfc   = OB'(ref_word[15:0]);
  assign t_rfcsb = OB'(ref_word[31:16]);
  assign t_xs    = OB'(ref_word[47:32]);

  assign t_rdpde = t_rl + t_pl + t_bur + ONE;
  assign t_wrpre = t_wl + t_bur + t_wr;
  assign t_wrpde = t_wl + t_pl + t_bur + ONE + t_wr;
  assign t_wrrds = t_wl + t_bur + t_wtrs;
  assign t_wrrdl = t_wl + t_bur + t_wtrl;
  assign t_rtprp = t_rtp + t_rp;
  assign t_rdsre = (t_rtprp > t_rdpde) ? t_rtprp : t_rdpde;

  always_comb begin
    unique case (off)
      dctc_pkg::O_ONE:         off_val = ONE;
      dctc_pkg::O_RCDRD1:      off_val = t_rcdrd + ONE;
      dctc_pkg::O_RCDWR1:      off_val = t_rcdwr + ONE;
      dctc_pkg::O_CCDL:        off_val = t_ccdl;
      dctc_pkg::O_CCDS:        off_val = t_ccds;
      dctc_pkg::O_WRPRE_M_RTP: off_val = t_wrpre - t_rtp;
      dctc_pkg::O_WRRDL:       off_val = t_wrrdl;
      dctc_pkg::O_WRRDS:       off_val = t_wrrds;
      dctc_pkg::O_XP:          off_val = t_xp;
      dctc_pkg::O_RTW:         off_val = t_rtw;
      dctc_pkg::O_RC:          off_val = t_rc;
      dctc_pkg::O_RRDL:        off_val = t_rrdl;
      dctc_pkg::O_RRDS:        off_val = t_rrds;
      dctc_pkg::O_RTPRP_M1:    off_val = t_rtprp - ONE;
      dctc_pkg::O_WRPRERP_M1:  off_val = t_wrpre + t_rp - ONE;
      dctc_pkg::O_RP_M1:       off_val = t_rp - ONE;
      dctc_pkg::O_XP_M1:       off_val = t_xp - ONE;
      dctc_pkg::O_RFC_M1:      off_val = t_rfc - ONE;
      dctc_pkg::O_RFCSB_M1:    off_val = t_rfcsb - ONE;
      dctc_pkg::O_RREFD_M1:    off_val = t_rrefd - ONE;
      dctc_pkg::O_XS_M1:       off_val = t_xs - ONE;
      dctc_pkg::O_FAW_M1:      off_val = t_faw - ONE;
      dctc_pkg::O_RAS1:        off_val = t_ras + ONE;
      dctc_pkg::O_RTP:         off_val = t_rtp;
      dctc_pkg::O_WRPRE:       off_val = t_wrpre;
      dctc_pkg::O_RFCSB:       off_val = t_rfcsb;
      dctc_pkg::O_RC1:         off_val = t_rc + ONE;
      dctc_pkg::O_RTPRP:       off_val = t_rtprp;
      dctc_pkg::O_WRPRERP:     off_val = t_wrpre + t_rp;
      dctc_pkg::O_RP:          off_val = t_rp;
      dctc_pkg::O_RFC:         off_val = t_rfc;
      dctc_pkg::O_XS:          off_val = t_xs;
      dctc_pkg::O_RRDL1:       off_val = t_rrdl + ONE;
      dctc_pkg::O_RRDS1:       off_val = t_rrds + ONE;
      dctc_pkg::O_REFCNT:      off_val = refcnt_zero ? t_rfcsb : t_rrefd;
      dctc_pkg::O_FAW:         off_val = t_faw;
      dctc_pkg::O_RDPDE:       off_val = t_rdpde;
      dctc_pkg::O_WRPDE:       off_val = t_wrpde;
      dctc_pkg::O_CKE:         off_val = t_cke;
      dctc_pkg::O_PD:          off_val = t_pd;
      dctc_pkg::O_RDSRE:       off_val = t_rdsre;
      dctc_pkg::O_CKESR:       off_val = t_ckesr;
      default:                 off_val = '0;
    endcase
  end

  // A negative sum clamps to zero and a sum past the time range saturates.
  assign sum = {{OB{1'b0}}, entry_time} + {{TIME_BITS{off_val[OB-1]}}, off_val};

  always_comb begin
    if (sum[W-1]) begin
      sat = '0;
    end else if (|sum[W-2:TIME_BITS]) begin
      sat = '1;
    end else begin
      sat = sum[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_valid_r <= 1'b0;
    end else begin
      cand_valid_r <= in_valid & entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    cand_time_r <= sat;
  end

  assign cand_valid = cand_valid_r;
  assign cand_time  = cand_time_r;

endmodule

// ===== hdl/dram_command_timing_checker.sv =====
// ----------------------------------------------------------------------------
// DRAM command timing checker
// A command has 2 to 15 timing rules, the bus rule included, read one per cycle
// in the rule state from the issue time memories or, for the activate window and
// bus rules, from registers. The result is registered once the wait state sees
// the pipeline drained; an unknown command goes straight to the wait state. A
// recorded command keeps busy high through write-back of its bank, group, rank
// and global entries. One command at a time; the receiver cannot stall. Reset
// idles the checker, clears flags, counters and timing words; bpr_r resets to 16.
// ----------------------------------------------------------------------------
module dram_command_timing_checker #(
  parameter int BANKS       = dctc_pkg::BANKS_DEF,
  parameter int BANK_GROUPS = dctc_pkg::BANK_GROUPS_DEF,
  parameter int RANKS       = dctc_pkg::RANKS_DEF,
  parameter int TIME_BITS   = dctc_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_cmd,
  input  logic [4:0]  in_bank,
  input  logic [2:0]  in_bank_group,
  input  logic        in_rank,
  input  logic [47:0] in_now,
  input  logic        in_record,
  output logic        out_valid,
  output logic [47:0] out_earliest_time,
  output logic        out_ready_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int BANK_W   = $clog2(BANKS);
  localparam int GRP_W    = (BANK_GROUPS > 1) ? $clog2(BANK_GROUPS) : 1;
  localparam int RANK_W   = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int A_DEPTH  = dctc_pkg::BANK_KINDS * BANKS;
  localparam int A_AW     = $clog2(A_DEPTH);
  localparam int RNK_BASE = dctc_pkg::GROUP_KINDS * BANK_GROUPS;
  localparam int GLB_BASE = RNK_BASE + dctc_pkg::RANK_KINDS * RANKS;
  localparam int B_DEPTH  = GLB_BASE + dctc_pkg::ALL_KINDS;
  localparam int B_AW     = $clog2(B_DEPTH);
  localparam int WIN      = dctc_pkg::ACT_WINDOW;
  localparam int WIN_W    = $clog2(WIN);
  localparam int FILL_W   = $clog2(WIN + 1);
  localparam int OB       = dctc_pkg::OUT_BITS;

  localparam logic [1:0] PH_GROUP  = 2'd0;
  localparam logic [1:0] PH_RANK   = 2'd1;
  localparam logic [1:0] PH_GLOBAL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RULE = 4'b0010,
    S_WAIT = 4'b0100,
    S_REC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [63:0] act_word_r, col_word_r, turn_word_r;
  logic [47:0] ref_word_r;
  logic [5:0]  bpr_r;

  dctc_pkg::kind_t      kind_r;
  logic                 known_r;
  logic                 rec_r;
  logic [BANK_W-1:0]    bank_r;
  logic [GRP_W-1:0]     grp_r;
  logic [RANK_W-1:0]    rank_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] soonest_r;
  logic [3:0]           step_idx_r;
  logic [1:0]           wr_ph_r;

  logic [6:0]           bank_mod, grp_mod, rank_mod;
  logic [63:0]          now64, out64;
  logic [TIME_BITS-1:0] in_time;
  logic                 accept;
  dctc_pkg::step_t      cur_step;

  logic                 p1_v_r;
  dctc_pkg::src_t       p1_src_r;
  dctc_pkg::off_t       p1_off_r;
  logic [TIME_BITS-1:0] p1_time_r;
  logic                 p1_tv_r;

  logic [TIME_BITS-1:0] row_t_r, col_t_r;
  logic                 row_v_r, col_v_r;
  logic [TIME_BITS-1:0] faw_r [RANKS][WIN];
  logic [FILL_W-1:0]    fill_r [RANKS];
  logic [4:0]           refcnt_r [RANKS];

  logic [A_AW-1:0]      a_rd_addr, a_wr_addr;
  logic [B_AW-1:0]      b_rd_addr, b_wr_addr;
  logic                 a_wr_en, b_wr_en;
  logic [TIME_BITS-1:0] a_rd_data, b_rd_data;
  logic                 a_rd_valid, b_rd_valid;

  logic [TIME_BITS-1:0] entry_time;
  logic                 entry_valid;
  logic                 cand_v;
  logic [TIME_BITS-1:0] cand_t;
  logic                 done;
  logic                 rec_ok;
  logic                 push;
  logic [TIME_BITS-1:0] row_new;
  logic [5:0]           cnt_inc;

  function automatic logic [B_AW-1:0] grp_addr(input logic [3:0] k, input logic [GRP_W-1:0] g);
    return B_AW'(k) * B_AW'(BANK_GROUPS) + B_AW'(g);
  endfunction

  function automatic logic [B_AW-1:0] rnk_addr(input logic [3:0] k, input logic [RANK_W-1:0] r);
    return B_AW'(RNK_BASE) + B_AW'(k) * B_AW'(RANKS) + B_AW'(r);
  endfunction

  function automatic logic [B_AW-1:0] glb_addr(input logic [3:0] k);
    return B_AW'(GLB_BASE) + B_AW'(k);
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start & ~busy;
  assign now64    = 64'(in_now);
  assign in_time  = now64[TIME_BITS-1:0];
  assign bank_mod = dctc_pkg::mod_small(7'(in_bank), 7'(BANKS));
  assign grp_mod  = dctc_pkg::mod_small(7'(in_bank_group), 7'(BANK_GROUPS));
  assign rank_mod = dctc_pkg::mod_small(7'(in_rank), 7'(RANKS));
  assign cur_step = dctc_pkg::rule_step(kind_r, step_idx_r);
  assign done     = ~p1_v_r & ~cand_v;
  assign rec_ok   = known_r & rec_r;
  assign push     = rec_ok & ((kind_r == dctc_pkg::K_ACT) || (kind_r == dctc_pkg::K_REFPB));
  assign row_new  = ((kind_r == dctc_pkg::K_ACT) && (now_r != '1)) ? now_r + TIME_BITS'(1)
                                                                     : now_r;
  assign cnt_inc  = {1'b0, refcnt_r[rank_r]} + 6'd1;
  assign out64    = 64'(known_r ? soonest_r : {TIME_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_word_r  <= '0;
      col_word_r  <= '0;
      turn_word_r <= '0;
      ref_word_r  <= '0;
      bpr_r       <= 6'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dctc_pkg::CFG_ACT_WORD:  act_word_r  <= cfg_data;
        dctc_pkg::CFG_COL_WORD:  col_word_r  <= cfg_data;
        dctc_pkg::CFG_TURN_WORD: turn_word_r <= cfg_data;
        dctc_pkg::CFG_REF_WORD:  ref_word_r  <= cfg_data[47:0];
        dctc_pkg::CFG_BPR:       bpr_r       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = (in_cmd <= dctc_pkg::CMD_SREFEX) ? S_RULE : S_WAIT;
      S_RULE: if (cur_step.last) state_nxt = S_WAIT;
      S_WAIT: if (done) state_nxt = rec_ok ? S_REC : S_IDLE;
      S_REC:  if (wr_ph_r == PH_GLOBAL) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_idx_r <= '0;
      wr_ph_r    <= PH_GROUP;
      p1_v_r     <= 1'b0;
      out_valid  <= 1'b0;
      row_v_r    <= 1'b0;
      col_v_r    <= 1'b0;
      for (int r = 0; r < RANKS; r++) begin
        fill_r[r]   <= '0;
        refcnt_r[r] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      p1_v_r    <= (state_r == S_RULE);
      out_valid <= (state_r == S_WAIT) & done;
      if (accept) begin
        step_idx_r <= '0;
        wr_ph_r    <= PH_GROUP;
      end
      if (state_r == S_RULE) begin
        step_idx_r <= step_idx_r + 4'd1;
      end
      if (state_r == S_REC) begin
        wr_ph_r <= wr_ph_r + 2'd1;
      end
      if ((state_r == S_WAIT) && done && rec_ok) begin
        if (kind_r <= dctc_pkg::K_WRA) begin
          col_v_r <= 1'b1;
        end else begin
          row_v_r <= 1'b1;
        end
        if (push) begin
          if (fill_r[rank_r] < FILL_W'(WIN)) begin
            fill_r[rank_r] <= fill_r[rank_r] + FILL_W'(1);
          end
        end
        if (kind_r == dctc_pkg::K_REFPB) begin
          refcnt_r[rank_r] <= (cnt_inc >= bpr_r) ? 5'd0 : cnt_inc[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r    <= dctc_pkg::cmd_kind(in_cmd);
      known_r   <= (in_cmd <= dctc_pkg::CMD_SREFEX);
      rec_r     <= in_record;
      bank_r    <= bank_mod[BANK_W-1:0];
      grp_r     <= grp_mod[GRP_W-1:0];
      rank_r    <= rank_mod[RANK_W-1:0];
      now_r     <= in_time;
      soonest_r <= in_time;
    end else if (cand_v && (cand_t > soonest_r)) begin
      soonest_r <= cand_t;
    end
    p1_src_r <= cur_step.src;
    p1_off_r <= cur_step.off;
    if (cur_step.src == dctc_pkg::SRC_FAW) begin
      p1_time_r <= faw_r[rank_r][0];
      p1_tv_r   <= (fill_r[rank_r] >= FILL_W'(WIN));
    end else begin
      p1_time_r <= (kind_r <= dctc_pkg::K_WRA) ? col_t_r : row_t_r;
      p1_tv_r   <= (kind_r <= dctc_pkg::K_WRA) ? col_v_r : row_v_r;
    end
    if ((state_r == S_WAIT) && done) begin
      out_earliest_time <= out64[OB-1:0];
      out_ready_res     <= known_r & (soonest_r == now_r);
      if (rec_ok) begin
        if (kind_r <= dctc_pkg::K_WRA) begin
          col_t_r <= now_r;
        end else begin
          row_t_r <= row_new;
        end
        if (push) begin
          if (fill_r[rank_r] >= FILL_W'(WIN)) begin
            for (int j = 0; j < WIN - 1; j++) begin
              faw_r[rank_r][j] <= faw_r[rank_r][j+1];
            end
            faw_r[rank_r][WIN-1] <= row_new;
          end else begin
            faw_r[rank_r][fill_r[rank_r][WIN_W-1:0]] <= row_new;
          end
        end
      end
    end
  end

  always_comb begin
    a_rd_addr = A_AW'(cur_step.kind) * A_AW'(BANKS) + A_AW'(bank_r);
    a_wr_addr = A_AW'(kind_r) * A_AW'(BANKS) + A_AW'(bank_r);
    a_wr_en   = (state_r == S_REC) && (wr_ph_r == PH_GROUP) &&
                (kind_r < 4'(dctc_pkg::BANK_KINDS));
    unique case (cur_step.src)
      dctc_pkg::SRC_GROUP: b_rd_addr = grp_addr(cur_step.kind, grp_r);
      dctc_pkg::SRC_RANK:  b_rd_addr = rnk_addr(cur_step.kind, rank_r);
      default:             b_rd_addr = glb_addr(cur_step.kind);
    endcase
    unique case (wr_ph_r)
      PH_GROUP: begin
        b_wr_addr = grp_addr(kind_r, grp_r);
        b_wr_en   = (state_r == S_REC) && (kind_r < 4'(dctc_pkg::GROUP_KINDS));
      end
      PH_RANK: begin
        b_wr_addr = rnk_addr(kind_r, rank_r);
        b_wr_en   = (state_r == S_REC) && (kind_r < 4'(dctc_pkg::RANK_KINDS));
      end
      default: begin
        b_wr_addr = glb_addr(kind_r);
        b_wr_en   = (state_r == S_REC);
      end
    endcase
  end

  dctc_issue_mem #(
    .DEPTH (A_DEPTH),
    .WIDTH (TIME_BITS)
  ) u_bank_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (a_wr_en),
    .wr_addr  (a_wr_addr),
    .wr_data  (now_r),
    .rd_addr  (a_rd_addr),
    .rd_data  (a_rd_data),
    .rd_valid (a_rd_valid)
  );

  dctc_issue_mem #(
    .DEPTH (B_DEPTH),
    .WIDTH (TIME_BITS)
  ) u_shared_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (b_wr_en),
    .wr_addr  (b_wr_addr),
    .wr_data  (now_r),
    .rd_addr  (b_rd_addr),
    .rd_data  (b_rd_data),
    .rd_valid (b_rd_valid)
  );

  always_comb begin
    unique case (p1_src_r)
      dctc_pkg::SRC_BANK: begin
        entry_time  = a_rd_data;
        entry_valid = a_rd_valid;
      end
      dctc_pkg::SRC_GROUP, dctc_pkg::SRC_RANK, dctc_pkg::SRC_GLOBAL: begin
        entry_time  = b_rd_data;
        entry_valid = b_rd_valid;
      end
      default: begin
        entry_time  = p1_time_r;
        entry_valid = p1_tv_r;
      end
    endcase
  end

  dctc_rule_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_rule_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (p1_v_r),
    .off         (p1_off_r),
    .act_word    (act_word_r),
    .col_word    (col_word_r),
    .turn_word   (turn_word_r),
    .ref_word    (ref_word_r),
    .refcnt_zero (refcnt_r[rank_r] == 5'd0),
    .entry_time  (entry_time),
    .entry_valid (entry_valid),
    .cand_valid  (cand_v),
    .cand_time   (cand_t)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!p1_v_r && !cand_v))
    else $error("Rule pipeline busy while idle.");

  a_rec_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REC && wr_ph_r == PH_GROUP) |-> out_valid)
    else $error("Write-back started without a result.");

  a_soonest_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RULE) |-> (soonest_r >= now_r))
    else $error("Earliest time fell below the current time.");

endmodule
